@@ rtl/hspo_pkg.sv @@
// shared constants, types and tables of the hall sensor position observer
package hspo_pkg;

  localparam int unsigned QBits       = 15;
  localparam int unsigned QScale      = 1 << QBits;
  localparam int unsigned SectorCount = 6;
  localparam int          SpeedLimit  = QScale / SectorCount;
  localparam int unsigned DivSteps    = QBits + 1;
  localparam int unsigned DivCntW     = $clog2(DivSteps);

  localparam logic [15:0] AlphaOne = 16'(QScale);

  localparam logic [1:0] CfgSectorMap      = 2'd0;
  localparam logic [1:0] CfgInvalidTimeout = 2'd1;
  localparam logic [1:0] CfgSpeedAlpha     = 2'd2;

  localparam logic [23:0] SectorMapReset      = 24'hE818EF;
  localparam logic [15:0] InvalidTimeoutReset = 16'd2;
  localparam logic [15:0] SpeedAlphaReset     = 16'd8192;

  typedef enum logic [1:0] {
    FaultNone        = 2'd0,
    FaultInvalidCode = 2'd1,
    FaultTransition  = 2'd2
  } fault_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic div_init;
    logic div_step;
    logic mul;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_edge;
    logic div_last;
  } status_t;

  function automatic logic [14:0] sector_angle(input logic [2:0] sector);
    logic [14:0] angle;
    case (sector)
      3'd1:    angle = 15'((QScale * 1) / SectorCount);
      3'd2:    angle = 15'((QScale * 2) / SectorCount);
      3'd3:    angle = 15'((QScale * 3) / SectorCount);
      3'd4:    angle = 15'((QScale * 4) / SectorCount);
      3'd5:    angle = 15'((QScale * 5) / SectorCount);
      default: angle = 15'd0;
    endcase
    return angle;
  endfunction

endpackage

@@ rtl/hspo_datapath.sv @@
// observer datapath: config registers, tracking state, edge-speed divider, filter, output register
module hspo_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hspo_pkg::cmd_t    cmd_i,
  output hspo_pkg::status_t status_o,
  input  logic [2:0]        hall_code_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  output logic [14:0]       electrical_angle_o,
  output logic [13:0]       electrical_speed_o,
  output logic              confidence_full_o,
  output logic              position_valid_o,
  output logic [1:0]        fault_code_o
);
  import hspo_pkg::*;

  localparam logic signed [18:0] SpeedMax = 19'(SpeedLimit);
  localparam logic signed [18:0] SpeedMin = -19'(SpeedLimit);

  logic [23:0] sector_map_q;
  logic [15:0] timeout_q;
  logic [15:0] alpha_q;

  logic [2:0]         code_q;
  logic [2:0]         prev_q;
  logic               seeded_q;
  logic               valid_q;
  logic               conf_q;
  logic [15:0]        ticks_q;
  logic [15:0]        inv_cnt_q;
  logic signed [15:0] speed_q;
  logic [14:0]        angle_q;
  fault_e             fault_q;
  logic               dir_back_q;

  logic [18:0]        rem_q;
  logic [15:0]        dvd_q;
  logic [15:0]        quot_q;
  logic [18:0]        divisor_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic signed [32:0] prod_q;

  logic [14:0] out_angle_q;
  logic [13:0] out_speed_q;
  logic        out_conf_q;
  logic        out_valid_flag_q;
  logic [1:0]  out_fault_q;

  logic [4:0]         bit_pos;
  logic [2:0]         sector;
  logic               code_bad;
  logic [2:0]         prev_p1;
  logic [2:0]         prev_m1;
  logic               step_fwd;
  logic               step_back;
  logic               changed;
  logic [15:0]        ticks_inc;
  logic [15:0]        inv_inc;
  logic [19:0]        trial;
  logic               trial_ge;
  logic signed [16:0] raw_s;
  logic signed [17:0] diff_w;
  logic signed [15:0] diff_s;
  logic [15:0]        alpha_sat;
  logic signed [32:0] prod_w;
  logic signed [17:0] prod_sh;
  logic signed [18:0] sum_w;
  logic signed [15:0] speed_new;

  assign bit_pos   = 5'(code_q) * 5'd3;
  assign sector    = sector_map_q[bit_pos +: 3];
  assign code_bad  = sector[2] & sector[1];
  assign prev_p1   = (prev_q == 3'd5) ? 3'd0 : prev_q + 3'd1;
  assign prev_m1   = (prev_q == 3'd0) ? 3'd5 : prev_q - 3'd1;
  assign step_fwd  = (sector == prev_p1);
  assign step_back = (sector == prev_m1);
  assign changed   = (sector != prev_q);
  assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign inv_inc   = (inv_cnt_q == 16'hFFFF) ? inv_cnt_q : inv_cnt_q + 16'd1;

  assign status_o.is_edge  = !code_bad && seeded_q && changed && (step_fwd || step_back);
  assign status_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));

  assign trial    = {rem_q, dvd_q[15]};
  assign trial_ge = (trial >= {1'b0, divisor_q});

  assign raw_s  = dir_back_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
  assign diff_w = 18'(raw_s) - 18'(speed_q);

  always_comb begin
    if (diff_w > 18'sd32767) begin
      diff_s = 16'sh7FFF;
    end else if (diff_w < -18'sd32768) begin
      diff_s = 16'sh8000;
    end else begin
      diff_s = diff_w[15:0];
    end
  end

  assign alpha_sat = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign prod_w    = 33'(diff_s) * 33'($signed({1'b0, alpha_sat}));
  assign prod_sh   = $signed(prod_q[32:15]);
  assign sum_w     = 19'(speed_q) + 19'(prod_sh);

  always_comb begin
    if (sum_w > SpeedMax) begin
      speed_new = 16'(SpeedMax);
    end else if (sum_w < SpeedMin) begin
      speed_new = 16'(SpeedMin);
    end else begin
      speed_new = sum_w[15:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_map_q <= SectorMapReset;
      timeout_q    <= InvalidTimeoutReset;
      alpha_q      <= SpeedAlphaReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSectorMap:      sector_map_q <= cfg_data_i;
        CfgInvalidTimeout: timeout_q    <= cfg_data_i[15:0];
        CfgSpeedAlpha:     alpha_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 3'd0;
      seeded_q  <= 1'b0;
      valid_q   <= 1'b0;
      conf_q    <= 1'b0;
      ticks_q   <= 16'd0;
      inv_cnt_q <= 16'd0;
      speed_q   <= 16'sd0;
      angle_q   <= 15'd0;
      fault_q   <= FaultNone;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.decode) begin
        if (code_bad) begin
          inv_cnt_q <= inv_inc;
          if (inv_inc >= timeout_q) begin
            valid_q <= 1'b0;
          end
          fault_q <= FaultInvalidCode;
        end else begin
          inv_cnt_q <= 16'd0;
          fault_q   <= FaultNone;
          if (!seeded_q) begin
            seeded_q <= 1'b1;
            prev_q   <= sector;
            angle_q  <= sector_angle(sector);
            ticks_q  <= 16'd0;
          end else begin
            ticks_q <= ticks_inc;
            if (changed) begin
              if (!(step_fwd || step_back)) begin
                valid_q <= 1'b0;
                conf_q  <= 1'b0;
                fault_q <= FaultTransition;
              end
            end else if (valid_q) begin
              angle_q <= angle_q + speed_q[14:0];
            end
          end
        end
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      if (cmd_i.sum) begin
        speed_q <= speed_new;
        angle_q <= sector_angle(sector);
        prev_q  <= sector;
        ticks_q <= 16'd0;
        valid_q <= 1'b1;
        conf_q  <= 1'b1;
      end
    end
  end

  // request capture, divider, multiplier and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q <= hall_code_i;
    end
    if (cmd_i.decode) begin
      dir_back_q <= step_back;
    end
    if (cmd_i.div_init) begin
      rem_q     <= 19'd0;
      dvd_q     <= 16'(QScale);
      quot_q    <= 16'd0;
      divisor_q <= {1'b0, ticks_q, 2'b00} + {2'b00, ticks_q, 1'b0};
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[14:0], 1'b0};
      if (trial_ge) begin
        rem_q  <= 19'(trial - {1'b0, divisor_q});
        quot_q <= {quot_q[14:0], 1'b1};
      end else begin
        rem_q  <= trial[18:0];
        quot_q <= {quot_q[14:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w;
    end
    if (cmd_i.emit) begin
      if (fault_q != FaultNone) begin
        out_angle_q      <= 15'd0;
        out_speed_q      <= 14'd0;
        out_conf_q       <= 1'b0;
        out_valid_flag_q <= 1'b0;
      end else begin
        out_angle_q      <= angle_q;
        out_speed_q      <= speed_q[13:0];
        out_conf_q       <= conf_q;
        out_valid_flag_q <= valid_q;
      end
      out_fault_q <= fault_q;
    end
  end

  assign electrical_angle_o = out_angle_q;
  assign electrical_speed_o = out_speed_q;
  assign confidence_full_o  = out_conf_q;
  assign position_valid_o   = out_valid_flag_q;
  assign fault_code_o       = out_fault_q;

endmodule

@@ rtl/hspo_ctrl.sv @@
// observer controller: sequences decode, division, filter and result hand-off
module hspo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  hspo_pkg::status_t status_i,
  output hspo_pkg::cmd_t    cmd_o
);
  import hspo_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDecode  = 3'd1;
  localparam logic [2:0] StDivInit = 3'd2;
  localparam logic [2:0] StDivRun  = 3'd3;
  localparam logic [2:0] StMul     = 3'd4;
  localparam logic [2:0] StSum     = 3'd5;
  localparam logic [2:0] StEmit    = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       emit_ok;

  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.is_edge ? StDivInit : StEmit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDivRun;
      end
      StDivRun: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/hall_sensor_position_observer.sv @@
// top level of the hall sensor position observer
// one request at a time: a code that is not a one-sector edge goes from decode straight to emit;
// an edge passes through the 16-step restoring divider for the speed and the filter before emit
// the result is loaded into the output register at emit (held back while a stalled result is there)
// and the next request can be taken while it waits there
// asynchronous active-low reset restores the register defaults and clears all tracking state
module hall_sensor_position_observer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  hall_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] electrical_angle_o,
  output logic [13:0] electrical_speed_o,
  output logic        confidence_full_o,
  output logic        position_valid_o,
  output logic [1:0]  fault_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import hspo_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  hspo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hspo_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .hall_code_i        (hall_code_i),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .electrical_angle_o (electrical_angle_o),
    .electrical_speed_o (electrical_speed_o),
    .confidence_full_o  (confidence_full_o),
    .position_valid_o   (position_valid_o),
    .fault_code_o       (fault_code_o)
  );

endmodule

@@ rtl/hspo_checker.sv @@
// port-level checker of the hall sensor position observer and its bind
module hspo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [14:0] electrical_angle_o,
  input logic [13:0] electrical_speed_o,
  input logic        confidence_full_o,
  input logic        position_valid_o,
  input logic [1:0]  fault_code_o
);
  import hspo_pkg::*;

  localparam logic signed [13:0] SpeedHi = 14'(SpeedLimit);
  localparam logic signed [13:0] SpeedLo = -14'(SpeedLimit);

  // faulted result carries nothing but the code
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fault_code_o != FaultNone) |->
      (electrical_angle_o == 15'd0) && (electrical_speed_o == 14'd0) &&
      !confidence_full_o && !position_valid_o)
    else $error("faulted result has nonzero fields");

  // validity is only ever granted together with full confidence
  a_valid_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && position_valid_o |-> confidence_full_o)
    else $error("position valid without full confidence");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(electrical_speed_o) <= SpeedHi) &&
                    ($signed(electrical_speed_o) >= SpeedLo))
    else $error("speed beyond one sector per tick");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while the first is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(electrical_angle_o) &&
      $stable(electrical_speed_o) && $stable(fault_code_o))
    else $error("stalled result changed");

endmodule

bind hall_sensor_position_observer hspo_checker u_hspo_checker (.*);
